[sv/srfoi_pkg.sv]
// Shared types, constant tables and base-case function for the FFT output index map.
package srfoi_pkg;

    localparam int LOG_MAX_SIZE_DEF = 16;
    localparam int LG_W             = 5;
    localparam int IND_W            = 16;
    localparam int FREQ_W           = 16;
    localparam int BASE_W           = 7;

    localparam logic [LG_W-1:0] LG_RESET     = 5'd7;
    localparam logic [LG_W-1:0] MIN_LG_CPLX  = 5'd4;
    localparam logic [LG_W-1:0] MIN_LG_REAL  = 5'd5;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_BAD_SIZE     = 2'd1,
        ST_OUT_OF_RANGE = 2'd2
    } t_status;

    // Control group that travels with each item down the walk.
    typedef struct packed {
        t_status              status;
        logic                 real_ph;
        logic [LG_W-1:0]      size_lg;
        logic [LG_W-1:0]      lg;
        logic [IND_W-1:0]     ind;
    } t_walk;

    localparam logic [3:0] PERM16 [16] = '{4'd0, 4'd8, 4'd12, 4'd4, 4'd14, 4'd6, 4'd2, 4'd10,
                                           4'd15, 4'd7, 4'd3, 4'd11, 4'd13, 4'd5, 4'd1, 4'd9};
    localparam logic [2:0] PERM8  [8]  = '{3'd0, 3'd4, 3'd6, 3'd2, 3'd7, 3'd3, 3'd5, 3'd1};
    localparam logic [1:0] PERM4  [4]  = '{2'd0, 2'd2, 2'd3, 2'd1};
    localparam logic [4:0] REAL32 [16] = '{5'd0, 5'd30, 5'd31, 5'd29, 5'd8, 5'd14, 5'd15, 5'd13,
                                           5'd12, 5'd22, 5'd23, 5'd21, 5'd4, 5'd6, 5'd7, 5'd5};

    localparam logic signed [2:0] OFF8 [8] = '{3'(0), 3'(-4), 3'(-2), 3'(2),
                                               3'(-1), 3'(3), 3'(-3), 3'(1)};
    localparam logic signed [1:0] OFF4 [4] = '{2'(0), 2'(-2), 2'(-1), 2'(1)};
    localparam logic signed [2:0] OFFR [4] = '{3'(0), 3'(-2), 3'(-1), 3'(-3)};

    // Complex base case for 16 to 128 points: a 4xk transpose followed by a table read.
    function automatic logic [BASE_W-1:0] base_c(input logic [BASE_W-1:0] ind,
                                                 input logic [LG_W-1:0] lg);
        logic [3:0]        t;
        logic [2:0]        r;
        logic [BASE_W-1:0] msk;
        logic [BASE_W-1:0] sum;
        logic signed [1:0] o4;
        t   = '0;
        r   = '0;
        msk = '0;
        sum = '0;
        o4  = '0;
        case (lg)
            5'd4: begin
                o4  = OFF4[ind[1:0]];
                sum = {3'b000, PERM4[ind[3:2]], 2'b00} + {{5{o4[1]}}, o4};
                msk = 7'h0F;
            end
            5'd5: begin
                t   = {2'b00, PERM4[ind[3:2]]};
                r   = {ind[4], ind[1:0]};
                msk = 7'h1F;
            end
            5'd6: begin
                t   = {1'b0, PERM8[ind[4:2]]};
                r   = {ind[5], ind[1:0]};
                msk = 7'h3F;
            end
            default: begin
                t   = PERM16[ind[5:2]];
                r   = {ind[6], ind[1:0]};
                msk = 7'h7F;
            end
        endcase
        if (lg != 5'd4) begin
            sum = {t, 3'b000} + {{4{OFF8[r][2]}}, OFF8[r]};
        end
        return sum & msk;
    endfunction

endpackage

[sv/split_radix_fft_output_index.sv]
// Top level of the split-radix FFT output slot to frequency index map.
//
//  channel   direction  contents                                   handshake
//  s_axis    in         tdata: slot_index; tuser: mode             tvalid/tready
//  m_axis    out        tdata: freq_index; tuser: status           tvalid/tready
//  cfg       in         i_cfg_data: log_size                       i_cfg_valid/o_cfg_ready
//
// One transaction is taken on s_axis in every cycle when m_axis is not stalled. Each item
// passes through an input decode register, (LOG_MAX_SIZE-5)/2 split levels (five at the
// default), a base-case stage and the output register. Every stage has its own valid bit and
// moves when the stage after it is empty or moving, so bubbles close up and a stall on m_axis
// holds every item. Reset is synchronous, active low, empties the pipeline and sets log_size
// to 7. Configuration is always ready, read on entry.
module split_radix_fft_output_index #(
    parameter int LOG_MAX_SIZE = srfoi_pkg::LOG_MAX_SIZE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] slot_index
    input  logic        s_axis_tuser,   // [0] mode
    // Output stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] freq_index
    output logic [1:0]  m_axis_tuser,   // [1:0] status
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [4:0]  i_cfg_data      // [4:0] log_size
);

    // Datapath width for offsets and results; at least one bit wider than the base-case value.
    localparam int DW   = (LOG_MAX_SIZE < 8) ? 8 : LOG_MAX_SIZE;
    localparam int SW   = $clog2(LOG_MAX_SIZE + 1);
    localparam int NLVL = (LOG_MAX_SIZE > 6) ? (LOG_MAX_SIZE - 5) / 2 : 0;
    localparam int BW   = srfoi_pkg::BASE_W;
    localparam int FW   = srfoi_pkg::FREQ_W;

    // Configuration register.
    logic [srfoi_pkg::LG_W-1:0] r_log_size;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_log_size <= srfoi_pkg::LG_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_log_size <= i_cfg_data;
        end
    end

    // Walk chain: point 0 is the decode register, point k+1 the output of level k.
    logic                 w_valid [NLVL+1];
    logic                 w_take  [NLVL+1];
    srfoi_pkg::t_walk     w_walk  [NLVL+1];
    logic [SW-1:0]        w_s     [NLVL+1];
    logic [DW-1:0]        w_d     [NLVL+1];

    // Input decode stage: size check first, then the index range check.
    logic                       r_v0;
    srfoi_pkg::t_walk           r_walk0;
    srfoi_pkg::t_walk           n_walk0;
    logic                       w_bad_size;
    logic                       w_oor;
    logic [srfoi_pkg::LG_W-1:0] w_lim;

    always_comb begin
        w_bad_size = (r_log_size < (s_axis_tuser ? srfoi_pkg::MIN_LG_REAL
                                                 : srfoi_pkg::MIN_LG_CPLX)) ||
                     (r_log_size > srfoi_pkg::LG_W'(LOG_MAX_SIZE));
        // The real ordering covers only the lower half of the slots.
        w_lim      = s_axis_tuser ? (r_log_size - 5'd1) : r_log_size;
        w_oor      = (s_axis_tdata >> w_lim) != '0;
        n_walk0.real_ph = s_axis_tuser;
        n_walk0.size_lg = r_log_size;
        n_walk0.lg      = r_log_size;
        n_walk0.ind     = s_axis_tdata;
        if (w_bad_size) begin
            n_walk0.status = srfoi_pkg::ST_BAD_SIZE;
        end else if (w_oor) begin
            n_walk0.status = srfoi_pkg::ST_OUT_OF_RANGE;
        end else begin
            n_walk0.status = srfoi_pkg::ST_OK;
        end
    end

    assign s_axis_tready = !r_v0 || w_take[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (s_axis_tready) begin
            r_v0 <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_walk0 <= n_walk0;
        end
    end

    assign w_valid[0] = r_v0;
    assign w_walk[0]  = r_walk0;
    assign w_s[0]     = '0;
    assign w_d[0]     = '0;

    // Split levels, one register stage each.
    for (genvar k = 0; k < NLVL; k++) begin : g_level
        srfoi_level #(
            .DW (DW),
            .SW (SW)
        ) u_level (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k]),
            .o_ready (w_take[k]),
            .i_walk  (w_walk[k]),
            .i_s     (w_s[k]),
            .i_d     (w_d[k]),
            .o_valid (w_valid[k+1]),
            .i_ready (w_take[k+1]),
            .o_walk  (w_walk[k+1]),
            .o_s     (w_s[k+1]),
            .o_d     (w_d[k+1])
        );
    end

    // Base-case stage. The real ordering ends at 32 or 64 points; at 64 points the upper
    // half of the slots turns into a 16-point complex base case with one more offset.
    logic                 r_vb;
    srfoi_pkg::t_walk     r_walkb;
    logic [BW-1:0]        r_vb_v;
    logic [SW-1:0]        r_vb_s;
    logic [DW-1:0]        r_vb_d;
    logic [BW-1:0]        n_vb_v;
    logic [SW-1:0]        n_vb_s;
    logic [DW-1:0]        n_vb_d;
    srfoi_pkg::t_walk     w_bw;
    logic                 w_take_out;

    assign w_bw = w_walk[NLVL];

    always_comb begin
        n_vb_s = w_s[NLVL];
        n_vb_d = w_d[NLVL];
        if (w_bw.real_ph) begin
            if (w_bw.lg == 5'd6 && w_bw.ind[4]) begin
                n_vb_d = w_d[NLVL] + ({DW{1'b1}} << w_s[NLVL]);
                n_vb_s = w_s[NLVL] + SW'(2);
                n_vb_v = srfoi_pkg::base_c({3'b000, w_bw.ind[3:0]}, 5'd4);
            end else if (w_bw.lg == 5'd6) begin
                n_vb_v = {1'b0, srfoi_pkg::REAL32[w_bw.ind[3:0]], 1'b0};
            end else begin
                n_vb_v = {2'b00, srfoi_pkg::REAL32[w_bw.ind[3:0]]};
            end
        end else begin
            n_vb_v = srfoi_pkg::base_c(w_bw.ind[BW-1:0], w_bw.lg);
        end
    end

    assign w_take_out   = !m_axis_tvalid || m_axis_tready;
    assign w_take[NLVL] = !r_vb || w_take_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
        end else if (w_take[NLVL]) begin
            r_vb <= w_valid[NLVL];
        end
        if (w_take[NLVL] && w_valid[NLVL]) begin
            r_walkb <= w_bw;
            r_vb_v  <= n_vb_v;
            r_vb_s  <= n_vb_s;
            r_vb_d  <= n_vb_d;
        end
    end

    // Output stage: shift the base value into place, add the gathered offset, keep log_size bits.
    logic          r_m_tvalid;
    logic [FW-1:0] r_m_tdata;
    logic [1:0]    r_m_tuser;
    logic [DW-1:0] w_res;
    logic [FW-1:0] w_freq;

    assign w_res = ((DW'(r_vb_v) << r_vb_s) + r_vb_d) & ~({DW{1'b1}} << r_walkb.size_lg);

    if (DW >= FW) begin : g_trunc
        assign w_freq = w_res[FW-1:0];
    end else begin : g_ext
        assign w_freq = {{(FW-DW){1'b0}}, w_res};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (w_take_out) begin
            r_m_tvalid <= r_vb;
        end
        if (w_take_out && r_vb) begin
            r_m_tdata <= (r_walkb.status == srfoi_pkg::ST_OK) ? w_freq : '0;
            r_m_tuser <= r_walkb.status;
        end
    end

    assign m_axis_tvalid = r_m_tvalid;
    assign m_axis_tdata  = r_m_tdata;
    assign m_axis_tuser  = r_m_tuser;

endmodule

[sv/srfoi_level.sv]
// One registered level of the split walk: an n/4 or n/8 split with its shift and offset, or a pass-through.
module srfoi_level #(
    parameter int DW = 16,
    parameter int SW = 5
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  srfoi_pkg::t_walk      i_walk,
    input  logic [SW-1:0]         i_s,
    input  logic [DW-1:0]         i_d,
    output logic                  o_valid,
    input  logic                  i_ready,
    output srfoi_pkg::t_walk      o_walk,
    output logic [SW-1:0]         o_s,
    output logic [DW-1:0]         o_d
);

    logic                           r_valid;
    srfoi_pkg::t_walk               r_walk;
    logic [SW-1:0]                  r_s;
    logic [DW-1:0]                  r_d;

    srfoi_pkg::t_walk               n_walk;
    logic [SW-1:0]                  n_s;
    logic [DW-1:0]                  n_d;

    logic [srfoi_pkg::LG_W-1:0]     w_sh;
    logic [1:0]                     w_r2;
    logic [2:0]                     w_r3;
    logic [srfoi_pkg::IND_W-1:0]    w_keep;
    logic signed [2:0]              w_off;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        n_walk = i_walk;
        n_s    = i_s;
        n_d    = i_d;
        w_sh   = i_walk.lg - 5'd3;
        w_r2   = 2'(i_walk.ind >> w_sh);
        w_r3   = 3'(i_walk.ind >> w_sh);
        w_keep = i_walk.ind & ~({srfoi_pkg::IND_W{1'b1}} << w_sh);
        w_off  = i_walk.real_ph ? srfoi_pkg::OFFR[w_r2] : srfoi_pkg::OFF8[w_r3];
        if (i_walk.status == srfoi_pkg::ST_OK) begin
            if ((i_walk.real_ph && i_walk.lg > 5'd6 && w_r2 == 2'd0) ||
                (!i_walk.real_ph && i_walk.lg > 5'd7 &&
                 (i_walk.ind >> (i_walk.lg - 5'd2)) == '0)) begin
                // Quarter split: only the shift grows.
                n_s       = i_s + SW'(2);
                n_walk.lg = i_walk.lg - 5'd2;
            end else if ((i_walk.real_ph && i_walk.lg > 5'd6) ||
                         (!i_walk.real_ph && i_walk.lg > 5'd7)) begin
                // Eighth split: an offset at the current shift, then the complex walk.
                n_walk.ind     = w_keep;
                n_walk.lg      = w_sh;
                n_walk.real_ph = 1'b0;
                n_d            = i_d + ({{(DW-3){w_off[2]}}, w_off} << i_s);
                n_s            = i_s + SW'(3);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_walk <= n_walk;
            r_s    <= n_s;
            r_d    <= n_d;
        end
    end

    assign o_valid = r_valid;
    assign o_walk  = r_walk;
    assign o_s     = r_s;
    assign o_d     = r_d;

endmodule

[sv/srfoi_checker.sv]
// Port-level checker for the FFT output index map, bound to the top level.
module srfoi_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tready,
    input logic        i_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] i_m_tdata,
    input logic [1:0]  i_m_tuser
);

    // An error status never carries a frequency index.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && i_m_tuser != srfoi_pkg::ST_OK) |-> (i_m_tdata == '0))
        else $error("error status with non-zero freq_index");

    // With the output free, the pipeline has room for a new transaction.
    a_input_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_m_tvalid || i_m_tready) |-> i_s_tready)
        else $error("input stalled while output is free");

    // Reset empties the output stage.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_tvalid)
        else $error("output valid straight after reset");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && !i_m_tready) |=>
        (i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tuser)))
        else $error("stalled result changed");

endmodule

bind split_radix_fft_output_index srfoi_checker u_srfoi_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tready (s_axis_tready),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata),
    .i_m_tuser  (m_axis_tuser)
);
